/* sv/decimal_fixed_point_alu_defines.svh */
// assertion macros used by the top-level rtl
`ifndef DECIMAL_FIXED_POINT_ALU_DEFINES_SVH
`define DECIMAL_FIXED_POINT_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define DFPA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define DFPA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define DFPA_ASSERT_IMP(label, clk, rst, ante, cons)
`define DFPA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/dfpa_pkg.sv */
package dfpa_pkg;

   localparam int WORD_W       = 64;
   localparam int HALF_W       = WORD_W / 2;
   localparam int OP_W         = 3;
   localparam int EXP_BITS_DEF = 4;

   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
   localparam logic [OP_W-1:0] OP_TRUNC = 3'd4;
   localparam logic [OP_W-1:0] OP_FRAC  = 3'd5;

   function automatic logic [WORD_W-1:0] pow10(input logic [3:0] e);
      logic [WORD_W-1:0] p;
      case (e)
         4'd0:    p = 64'd1;
         4'd1:    p = 64'd10;
         4'd2:    p = 64'd100;
         4'd3:    p = 64'd1000;
         4'd4:    p = 64'd10000;
         4'd5:    p = 64'd100000;
         4'd6:    p = 64'd1000000;
         4'd7:    p = 64'd10000000;
         4'd8:    p = 64'd100000000;
         4'd9:    p = 64'd1000000000;
         4'd10:   p = 64'd10000000000;
         4'd11:   p = 64'd100000000000;
         4'd12:   p = 64'd1000000000000;
         4'd13:   p = 64'd10000000000000;
         4'd14:   p = 64'd100000000000000;
         default: p = 64'd1000000000000000;
      endcase
      return p;
   endfunction

endpackage

/* sv/dfpa_if.sv */
interface dfpa_req_if;
   logic                           valid;
   logic                           ready;
   logic [dfpa_pkg::OP_W-1:0]      req_type;
   logic [dfpa_pkg::WORD_W-1:0]    operand_a;
   logic [dfpa_pkg::WORD_W-1:0]    operand_b;
   modport source (output valid, req_type, operand_a, operand_b, input ready);
   modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface dfpa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dfpa_pkg::WORD_W-1:0]    result;
   logic                           divide_by_zero;
   modport source (output valid, result, divide_by_zero, input ready);
   modport sink (input valid, result, divide_by_zero, output ready);
endinterface

/* sv/dfpa_mul.sv */
module dfpa_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dfpa_pkg::WORD_W-1:0]   mul_a,
   input  logic [dfpa_pkg::WORD_W-1:0]   mul_b,
   output logic                          done,
   output logic [dfpa_pkg::WORD_W-1:0]   product
);

   localparam int W = dfpa_pkg::WORD_W;
   localparam int H = dfpa_pkg::HALF_W;

   logic [W-1:0] a_ff, b_ff, acc_ff, acc_in, pp_ff, pp_in;
   logic [1:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [H-1:0] x, y;

   // low word only: lo*lo + (lo*hi + hi*lo) << H
   always_comb begin
      case (cnt_ff)
         2'd1:    begin x = a_ff[H-1:0]; y = b_ff[W-1:H]; end
         2'd2:    begin x = a_ff[W-1:H]; y = b_ff[H-1:0]; end
         default: begin x = a_ff[H-1:0]; y = b_ff[H-1:0]; end
      endcase
      pp_in = {{H{1'b0}}, x} * {{H{1'b0}}, y};
      case (cnt_ff) inside
         2'd1:       acc_in = acc_ff + pp_ff;
         2'd2, 2'd3: acc_in = acc_ff + {pp_ff[H-1:0], {H{1'b0}}};
         default:    acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= mul_a;
         b_ff   <= mul_b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         pp_ff  <= pp_in;
         acc_ff <= acc_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* sv/dfpa_div.sv */
module dfpa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dfpa_pkg::WORD_W-1:0]   dividend,
   input  logic [dfpa_pkg::WORD_W-1:0]   divisor,
   output logic                          done,
   output logic [dfpa_pkg::WORD_W-1:0]   quotient,
   output logic [dfpa_pkg::WORD_W-1:0]   remainder
);

   localparam int W      = dfpa_pkg::WORD_W;
   localparam int CNT_W  = $clog2(W);

   logic [W-1:0]     quo_ff, quo_in, rem_ff, rem_in, dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [W:0]       shifted, diff;

   // restoring, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (!diff[W]) begin
         rem_in = diff[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b1};
      end else begin
         rem_in = shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* sv/decimal_fixed_point_alu.sv */
// channel  dir  handshake     word
// req_bus  in   valid/ready   req_type, operand_a, operand_b
// rsp_bus  out  valid/ready   result, divide_by_zero
//
// one word at a time; req ready only while idle
// after accept, add, sub and mul run a 4-step multiply, then a 64-step divide
// trunc, frac: one 64-step divide; div: two, or one when the first quotient is zero
// unused codes go straight to output; radix-2 divider, one quotient bit per cycle
// reset is synchronous; a stalled result holds in the output register
// the next word is accepted at the earliest in the cycle after the result is taken
`include "decimal_fixed_point_alu_defines.svh"

module decimal_fixed_point_alu #(
   parameter int EXP_BITS = dfpa_pkg::EXP_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dfpa_req_if.sink    req_bus,
   dfpa_rsp_if.source  rsp_bus
);

   localparam int W     = dfpa_pkg::WORD_W;
   localparam int VAL_W = W - EXP_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV1 = 3'd2;
   localparam logic [2:0] S_DIV2 = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [dfpa_pkg::OP_W-1:0]   op_ff, op_in;
   logic [EXP_BITS-1:0]         ea_ff, ea_in, eb;
   logic [VAL_W-1:0]            va_ff, va_in, vb;
   logic [W-1:0]                sb_ff, sb_in, sa;
   logic [W-1:0]                result_ff, result_in;
   logic                        dz_ff, dz_in;
   logic                        mul_start_ff, mul_start_in;
   logic                        div_start_ff, div_start_in;
   logic [W-1:0]                mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [W-1:0]                dvd_ff, dvd_in, dvs_ff, dvs_in;
   logic                        mul_done, div_done;
   logic [W-1:0]                product, quotient, remainder;
   logic                        accept;

   dfpa_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mul_a   (mul_a_ff),
      .mul_b   (mul_b_ff),
      .done    (mul_done),
      .product (product)
   );

   dfpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (dvd_ff),
      .divisor   (dvs_ff),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign accept                 = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid          = (state_ff == S_OUT);
   assign rsp_bus.result         = result_ff;
   assign rsp_bus.divide_by_zero = dz_ff;

   function automatic logic [W-1:0] pack(input logic [EXP_BITS-1:0] e,
                                         input logic [W-1:0] v);
      return (v << EXP_BITS) | W'(e);
   endfunction

   always_comb begin
      eb           = req_bus.operand_b[EXP_BITS-1:0];
      vb           = req_bus.operand_b[W-1:EXP_BITS];
      sa           = dfpa_pkg::pow10(4'(req_bus.operand_a[EXP_BITS-1:0]));
      state_in     = state_ff;
      op_in        = op_ff;
      ea_in        = ea_ff;
      va_in        = va_ff;
      sb_in        = sb_ff;
      result_in    = result_ff;
      dz_in        = dz_ff;
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_bus.req_type;
               ea_in     = req_bus.operand_a[EXP_BITS-1:0];
               va_in     = req_bus.operand_a[W-1:EXP_BITS];
               sb_in     = dfpa_pkg::pow10(4'(eb));
               result_in = '0;
               dz_in     = 1'b0;
               unique case (req_bus.req_type) inside
                  dfpa_pkg::OP_ADD, dfpa_pkg::OP_SUB: begin
                     mul_a_in     = W'(vb);
                     mul_b_in     = sa;
                     mul_start_in = 1'b1;
                     state_in     = S_MUL;
                  end
                  dfpa_pkg::OP_MUL: begin
                     mul_a_in     = W'(req_bus.operand_a[W-1:EXP_BITS]);
                     mul_b_in     = W'(vb);
                     mul_start_in = 1'b1;
                     state_in     = S_MUL;
                  end
                  dfpa_pkg::OP_DIV: begin
                     dvd_in       = W'(vb);
                     dvs_in       = dfpa_pkg::pow10(4'(eb));
                     div_start_in = 1'b1;
                     state_in     = S_DIV1;
                  end
                  dfpa_pkg::OP_TRUNC, dfpa_pkg::OP_FRAC: begin
                     dvd_in       = W'(req_bus.operand_a[W-1:EXP_BITS]);
                     dvs_in       = sa;
                     div_start_in = 1'b1;
                     state_in     = S_DIV1;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_MUL: begin
            if (mul_done) begin
               dvd_in       = product;
               dvs_in       = sb_ff;
               div_start_in = 1'b1;
               state_in     = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_done) begin
               state_in = S_OUT;
               unique case (op_ff)
                  dfpa_pkg::OP_ADD:   result_in = pack(ea_ff, W'(va_ff) + quotient);
                  dfpa_pkg::OP_SUB:   result_in = pack(ea_ff, W'(va_ff) - quotient);
                  dfpa_pkg::OP_MUL:   result_in = pack(ea_ff, quotient);
                  dfpa_pkg::OP_TRUNC: result_in = quotient;
                  dfpa_pkg::OP_FRAC:  result_in = remainder;
                  dfpa_pkg::OP_DIV: begin
                     if (quotient == '0) begin
                        result_in = '0;
                        dz_in     = 1'b1;
                     end else begin
                        dvd_in       = W'(va_ff);
                        dvs_in       = quotient;
                        div_start_in = 1'b1;
                        state_in     = S_DIV2;
                     end
                  end
                  default: result_in = '0;
               endcase
            end
         end
         S_DIV2: begin
            if (div_done) begin
               result_in = pack(ea_ff, quotient);
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      ea_ff     <= ea_in;
      va_ff     <= va_in;
      sb_ff     <= sb_in;
      result_ff <= result_in;
      dz_ff     <= dz_in;
      mul_a_ff  <= mul_a_in;
      mul_b_ff  <= mul_b_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
   end

   `DFPA_ASSERT_IMP(a_ready_no_rsp, clock, reset, req_bus.ready, !rsp_bus.valid)
   `DFPA_ASSERT_IMP(a_mul_done_state, clock, reset, mul_done, state_ff == S_MUL)
   `DFPA_ASSERT_IMP(a_div_done, clock, reset, div_done, state_ff == S_DIV1 || state_ff == S_DIV2)
   `DFPA_ASSERT_IMP(a_dz_zero, clock, reset, rsp_bus.valid && rsp_bus.divide_by_zero, rsp_bus.result == '0)
   `DFPA_ASSERT_NXT(a_accept_busy, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)

endmodule

/* tb/sv/decimal_fixed_point_alu_tb.sv */
`timescale 1ns / 1ps

module decimal_fixed_point_alu_tb;

   localparam int WORD_W = dfpa_pkg::WORD_W;
   localparam int OP_W = dfpa_pkg::OP_W;
   localparam int EXP_BITS = dfpa_pkg::EXP_BITS_DEF;
   localparam int VAL_W = WORD_W - EXP_BITS;
   localparam logic [WORD_W-1:0] EXP_MASK = (64'd1 << EXP_BITS) - 64'd1;
   localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
   localparam int RANDOM_WORDS = 1200;
   localparam int DRAIN_CYCLES = 200;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [OP_W-1:0] op_type;

   typedef struct packed {
      word_type result;
      logic     divide_by_zero;
   } alu_out_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_SPARSE
   } stall_mode_type;

   logic clock;
   logic reset;

   dfpa_req_if req_bus ();
   dfpa_rsp_if rsp_bus ();

   decimal_fixed_point_alu #(
      .EXP_BITS(EXP_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   alu_out_type pending_results[$];
   int          error_count = 0;
   int          burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic word_type ten_pow(input logic [3:0] e);
      word_type p;
      p = 64'd1;
      for (int i = 0; i < e; i++) p = p * 64'd10;
      return p;
   endfunction

   function automatic word_type pack_word(input word_type e, input word_type v);
      return (e & EXP_MASK) | (v << EXP_BITS);
   endfunction

   function automatic alu_out_type predict_alu(input op_type op, input word_type a,
                                               input word_type b);
      word_type    ea, eb, va, vb, sa, sb, d;
      alu_out_type r;
      ea = a & EXP_MASK;
      eb = b & EXP_MASK;
      va = a >> EXP_BITS;
      vb = b >> EXP_BITS;
      sa = ten_pow(ea[3:0]);
      sb = ten_pow(eb[3:0]);
      r.result = '0;
      r.divide_by_zero = 1'b0;
      case (op)
         dfpa_pkg::OP_ADD: r.result = pack_word(ea, va + (vb * sa) / sb);
         dfpa_pkg::OP_SUB: r.result = pack_word(ea, va - (vb * sa) / sb);
         dfpa_pkg::OP_MUL: r.result = pack_word(ea, (va * vb) / sb);
         dfpa_pkg::OP_DIV: begin
            d = vb / sb;
            if (d == '0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               r.result = pack_word(ea, va / d);
            end
         end
         dfpa_pkg::OP_TRUNC: r.result = va / sa;
         dfpa_pkg::OP_FRAC:  r.result = va % sa;
         default:            r.result = '0;
      endcase
      return r;
   endfunction

   function automatic word_type rand_word();
      word_type e, v, k;
      e = word_type'($urandom_range(0, 15));
      k = word_type'($urandom_range(0, 999));
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: v = word_type'($urandom_range(0, 65535));
         2: v = k * ten_pow(e[3:0]) + word_type'($urandom_range(0, 9));
         default: v = $urandom_range(0, 1) ? word_type'({VAL_W{1'b1}}) : '0;
      endcase
      return pack_word(e, v);
   endfunction

   task automatic idle_cycles(input int n);
      req_bus.valid <= 1'b0;
      req_bus.req_type <= op_type'($urandom_range(0, 7));
      req_bus.operand_a <= {$urandom, $urandom};
      req_bus.operand_b <= {$urandom, $urandom};
      repeat (n) @(posedge clock);
   endtask

   task automatic send_word(input op_type op, input word_type a, input word_type b);
      req_bus.valid <= 1'b1;
      req_bus.req_type <= op;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(predict_alu(op, a, b));
      // bursts of random length separated by random gaps
      if (burst_left == 0) begin
         idle_cycles($urandom_range(1, 16));
         burst_left = $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic test_add_sub_extremes();
      send_word(dfpa_pkg::OP_ADD, '1, '1);
      send_word(dfpa_pkg::OP_ADD, '0, '0);
      send_word(dfpa_pkg::OP_ADD, pack_word(0, 12345), pack_word(15, ten_pow(15) * 7));
      send_word(dfpa_pkg::OP_SUB, pack_word(2, 5), pack_word(2, 7));
      send_word(dfpa_pkg::OP_SUB, pack_word(15, 1), pack_word(0, {VAL_W{1'b1}}));
      send_word(dfpa_pkg::OP_SUB, '1, '0);
   endtask

   task automatic test_mul_div();
      send_word(dfpa_pkg::OP_MUL, '1, '1);
      send_word(dfpa_pkg::OP_MUL, pack_word(1, 3), pack_word(1, 25));
      send_word(dfpa_pkg::OP_MUL, pack_word(7, {VAL_W{1'b1}}), pack_word(0, 2));
      send_word(dfpa_pkg::OP_DIV, '1, pack_word(0, 1));
      send_word(dfpa_pkg::OP_DIV, pack_word(3, 987654), pack_word(15, ten_pow(15)));
      send_word(dfpa_pkg::OP_DIV, pack_word(4, 100), pack_word(2, 1234));
   endtask

   task automatic test_div_zero();
      send_word(dfpa_pkg::OP_DIV, '1, '0);
      send_word(dfpa_pkg::OP_DIV, pack_word(5, 42), pack_word(3, ten_pow(3) - 1));
      send_word(dfpa_pkg::OP_DIV, pack_word(9, 1),
                {{VAL_W{1'b0}}, 4'hf} | pack_word(15, ten_pow(15) - 1));
   endtask

   task automatic test_trunc_frac();
      send_word(dfpa_pkg::OP_TRUNC, pack_word(0, 12345), '1);
      send_word(dfpa_pkg::OP_TRUNC, '1, '0);
      send_word(dfpa_pkg::OP_TRUNC, pack_word(3, 12345), '0);
      send_word(dfpa_pkg::OP_FRAC, pack_word(0, 12345), '1);
      send_word(dfpa_pkg::OP_FRAC, '1, '0);
      send_word(dfpa_pkg::OP_FRAC, pack_word(3, 12345), '0);
   endtask

   task automatic test_unused_codes();
      send_word(OP_RSVD6, '1, '1);
      send_word(OP_RSVD7, pack_word(2, 777), pack_word(0, 3));
   endtask

   task automatic test_random_mix();
      op_type op;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 99) < 96) begin
            op = op_type'($urandom_range(dfpa_pkg::OP_ADD, dfpa_pkg::OP_FRAC));
         end else begin
            op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
         end
         send_word(op, rand_word(), rand_word());
      end
   endtask

   // result side stalls on its own schedule
   initial begin
      stall_mode_type mode;
      int             cnt;
      mode = STALL_NONE;
      cnt = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cnt++;
         if (cnt % 400 == 0) mode = stall_mode_type'($urandom_range(0, 2));
         case (mode)
            STALL_NONE:   rsp_bus.ready <= 1'b1;
            STALL_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default:      rsp_bus.ready <= (cnt % 8 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      alu_out_type exp_word;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected word: result %h divide_by_zero %b", $realtime,
                     rsp_bus.result, rsp_bus.divide_by_zero);
            error_count++;
         end else begin
            exp_word = pending_results.pop_front();
            if (rsp_bus.result !== exp_word.result) begin
               $display("%0t result mismatch: expected %h actual %h", $realtime,
                        exp_word.result, rsp_bus.result);
               error_count++;
            end
            if (rsp_bus.divide_by_zero !== exp_word.divide_by_zero) begin
               $display("%0t divide_by_zero mismatch: expected %b actual %b", $realtime,
                        exp_word.divide_by_zero, rsp_bus.divide_by_zero);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= dfpa_pkg::OP_ADD;
      req_bus.operand_a <= '0;
      req_bus.operand_b <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_add_sub_extremes();
      test_mul_div();
      test_div_zero();
      test_trunc_frac();
      test_unused_codes();
      test_random_mix();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/dfpa_pkg.sv
sv/dfpa_if.sv
sv/dfpa_mul.sv
sv/dfpa_div.sv
sv/decimal_fixed_point_alu.sv
tb/sv/decimal_fixed_point_alu_tb.sv
